@@ rtl/lfia_pkg.sv @@
`default_nettype none
// ============================================================================
// Lowest free ID allocator package
// Shared widths, operation and status codes, controller states and the
// command bundle between the controller and the datapath.
// ============================================================================
package lfia_pkg;

    localparam int DEF_NUM_IDS = 64;
    localparam int ADDR_SPACE  = 64;
    localparam int NUMBER_W    = 6;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int TDATA_W     = 8;
    localparam int GRP_SIZE    = 8;
    localparam int GRP_IDX_W   = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_REQUEST = 2'd0,
        MODE_CLAIM   = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_TAKEN = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } dp_cmd_t;

    // Only numbers below both the set size and the 6-bit address space exist.
    function automatic int id_limit(input int num_ids);
        int lim;
        begin
            lim = (num_ids < ADDR_SPACE) ? num_ids : ADDR_SPACE;
            return lim;
        end
    endfunction

    // Position of the lowest zero in one group of taken bits.
    function automatic logic [GRP_IDX_W-1:0] first_zero(input logic [GRP_SIZE-1:0] bits);
        logic [GRP_IDX_W-1:0] pos;
        begin
            pos = '0;
            for (int i = GRP_SIZE - 1; i >= 0; i--) begin
                if (!bits[i]) begin
                    pos = GRP_IDX_W'(i);
                end
            end
            return pos;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/lowest_free_id_allocator.sv @@
`default_nettype none
// ============================================================================
// Lowest free ID allocator
// Keeps a bitmap of identification numbers in use; hands out the lowest free
// number, claims and releases given numbers, and clears the whole set.
// ============================================================================
//
//  Channel   Direction  tdata                         tuser
//  --------  ---------  ----------------------------  ---------------------
//  s_*       in         [5:0] number, [7:6] zero      [1:0] mode
//  m_*       out        [5:0] granted, [7:6] zero     [1:0] status
//
// Each transaction passes through accept, a search in which every group of
// eight taken bits is reduced to a free flag and a lowest-free position
// (registered), and a commit in which the lowest free group is chosen, the
// bitmap is updated and the result register is loaded. A new transaction
// is accepted in the cycle after a commit, so the allocator takes no new
// transaction while one is still in its search or commit.
// Reset clears the bitmap at once, so no clearing pass follows it.
// A result waits in the output register while m_tready is low; the next
// transaction is still accepted and searched, and holds at commit until the
// waiting result has been taken.
//
// Mode codes: 0 request lowest free, 1 claim number, 2 release number,
// 3 clear all. Status codes: 0 done, 1 number already taken, 2 set full
// (also returned for a claim of a number outside the set).
// ============================================================================
module lowest_free_id_allocator #(
    parameter int NUM_IDS = lfia_pkg::DEF_NUM_IDS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lfia_pkg::TDATA_W-1:0]     s_tdata,   // [5:0] number
    input  wire logic [lfia_pkg::MODE_W-1:0]      s_tuser,   // [1:0] mode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [lfia_pkg::TDATA_W-1:0]     m_tdata,   // [5:0] granted
    output logic      [lfia_pkg::STATUS_W-1:0]    m_tuser    // [1:0] status
);

    lfia_pkg::dp_cmd_t                 cmd;
    logic [lfia_pkg::NUMBER_W-1:0]     granted;

    // The controller sequences each transaction and owns the output valid flag.
    lfia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the bitmap, the search and the result payload.
    lfia_dpath #(
        .NUM_IDS (NUM_IDS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_mode   (s_tuser),
        .in_number (s_tdata[lfia_pkg::NUMBER_W-1:0]),
        .granted   (granted),
        .status    (m_tuser)
    );

    // Upper tdata bits are padding to a whole byte.
    assign m_tdata = {{(lfia_pkg::TDATA_W - lfia_pkg::NUMBER_W){1'b0}}, granted};

endmodule
`default_nettype wire

@@ rtl/lfia_ctrl.sv @@
`default_nettype none
// ============================================================================
// Lowest free ID allocator controller
// Sequences accept, search and commit, and owns the result valid flag.
// ============================================================================
module lfia_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output lfia_pkg::dp_cmd_t      cmd
);

    lfia_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == lfia_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            lfia_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lfia_pkg::S_SCAN;
                end
            end
            lfia_pkg::S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = lfia_pkg::S_COMMIT;
            end
            lfia_pkg::S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = lfia_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lfia_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lfia_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // An accepted transaction always moves on to the search.
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == lfia_pkg::S_SCAN))
        else $error("accepted transaction did not enter the search");

    // The search state always hands over directly to the commit state.
    a_scan_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfia_pkg::S_SCAN) |=> (state_reg == lfia_pkg::S_COMMIT))
        else $error("search did not hand over to commit");

    // A commit never overwrites a result still waiting to be taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !cmd.commit)
        else $error("commit overwrote a pending result");

    // A commit leaves a valid result and returns to idle.
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (m_tvalid && state_reg == lfia_pkg::S_IDLE))
        else $error("commit did not present a result");
`endif

endmodule
`default_nettype wire

@@ rtl/lfia_dpath.sv @@
`default_nettype none
// ============================================================================
// Lowest free ID allocator datapath
// Holds the taken bitmap, the two-stage lowest-free search and the result
// register.
// ============================================================================
module lfia_dpath #(
    parameter int NUM_IDS = lfia_pkg::DEF_NUM_IDS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lfia_pkg::dp_cmd_t               cmd,
    input  wire logic [lfia_pkg::MODE_W-1:0]     in_mode,
    input  wire logic [lfia_pkg::NUMBER_W-1:0]   in_number,
    output logic      [lfia_pkg::NUMBER_W-1:0]   granted,
    output logic      [lfia_pkg::STATUS_W-1:0]   status
);

    localparam int ID_LIMIT = lfia_pkg::id_limit(NUM_IDS);
    localparam int NUM_GRP  = (ID_LIMIT + lfia_pkg::GRP_SIZE - 1) / lfia_pkg::GRP_SIZE;
    localparam int PAD_W    = NUM_GRP * lfia_pkg::GRP_SIZE;

    logic [ID_LIMIT-1:0]                 taken_reg, taken_next;
    lfia_pkg::mode_t                     mode_reg;
    logic [lfia_pkg::NUMBER_W-1:0]       num_reg;
    logic [lfia_pkg::NUMBER_W-1:0]       granted_reg, granted_next;
    lfia_pkg::status_t                   status_reg, status_next;

    logic [PAD_W-1:0]                    padded;
    logic [NUM_GRP-1:0]                  grp_free_reg;
    logic [lfia_pkg::GRP_IDX_W-1:0]      grp_idx_reg [NUM_GRP];

    logic                                found;
    logic [lfia_pkg::NUMBER_W-1:0]       grant_id;
    logic [ID_LIMIT-1:0]                 grant_dec;
    logic [ID_LIMIT-1:0]                 num_dec;
    logic                                num_in_range;
    logic                                num_busy;

    // Bits past the end of the set read as taken so the search never picks them.
    always_comb
    begin
        padded                 = '1;
        padded[ID_LIMIT-1:0]   = taken_reg;
    end

    // Second stage: pick the lowest group that has a free bit.
    always_comb
    begin
        found    = 1'b0;
        grant_id = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                found    = 1'b1;
                grant_id = lfia_pkg::NUMBER_W'(g * lfia_pkg::GRP_SIZE)
                         + lfia_pkg::NUMBER_W'(grp_idx_reg[g]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < ID_LIMIT; i++)
        begin
            grant_dec[i] = (grant_id == lfia_pkg::NUMBER_W'(i));
            num_dec[i]   = (num_reg == lfia_pkg::NUMBER_W'(i));
        end
    end

    assign num_in_range = |num_dec;
    assign num_busy     = |(taken_reg & num_dec);

    always_comb
    begin
        taken_next   = taken_reg;
        granted_next = num_reg;
        status_next  = lfia_pkg::ST_DONE;
        case (mode_reg)
            lfia_pkg::MODE_REQUEST:
            begin
                if (found)
                begin
                    taken_next   = taken_reg | grant_dec;
                    granted_next = grant_id;
                end
                else
                begin
                    granted_next = '0;
                    status_next  = lfia_pkg::ST_FULL;
                end
            end
            lfia_pkg::MODE_CLAIM:
            begin
                if (!num_in_range)
                begin
                    status_next = lfia_pkg::ST_FULL;
                end
                else if (num_busy)
                begin
                    status_next = lfia_pkg::ST_TAKEN;
                end
                else
                begin
                    taken_next = taken_reg | num_dec;
                end
            end
            lfia_pkg::MODE_RELEASE:
            begin
                taken_next = taken_reg & ~num_dec;
            end
            lfia_pkg::MODE_CLEAR:
            begin
                taken_next = '0;
            end
            default:
            begin
                taken_next = taken_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else if (cmd.commit)
        begin
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= lfia_pkg::mode_t'(in_mode);
            num_reg  <= in_number;
        end
        if (cmd.scan)
        begin
            for (int g = 0; g < NUM_GRP; g++)
            begin
                grp_free_reg[g] <= ~&padded[g*lfia_pkg::GRP_SIZE +: lfia_pkg::GRP_SIZE];
                grp_idx_reg[g]  <= lfia_pkg::first_zero(
                                       padded[g*lfia_pkg::GRP_SIZE +: lfia_pkg::GRP_SIZE]);
            end
        end
        if (cmd.commit)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    assign granted = granted_reg;
    assign status  = status_reg;

endmodule
`default_nettype wire
